@@ rtl/core/weighted_affine_residual_sum_macros.svh @@
// Assertion macros shared by the checker of the weighted affine residual sum block.
`ifndef WEIGHTED_AFFINE_RESIDUAL_SUM_MACROS_SVH
`define WEIGHTED_AFFINE_RESIDUAL_SUM_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WARS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WARS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/wars_pkg.sv @@
// Package with the types, sizes and codes of the weighted affine residual sum block.
`timescale 1ns / 1ps
package wars_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 10;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 64;

  // Divider: dividend magnitude, divisor and quotient widths.
  localparam int MAG_W  = 63;
  localparam int Q_W    = 61;
  localparam int QUOT_W = 31;

  // Square root: radicand and root widths.
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ROW    = 2'd1,
    KIND_WEIGHT = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [31:0] fz_im;
    logic signed [31:0] fz_re;
    logic signed [31:0] v_im;
    logic signed [31:0] v_re;
  } point_t;

  localparam int POINT_W = $bits(point_t);

endpackage

@@ rtl/core/wars_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module wars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/wars_div.sv @@
// Restoring divider giving min(floor(mag * 2^16 / q), 2^31 - 1), one quotient bit a cycle.
`timescale 1ns / 1ps
module wars_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wars_pkg::MAG_W-1:0] mag_i,
  input  logic [wars_pkg::Q_W-1:0]   q_i,
  output logic                       done_o,
  output logic [wars_pkg::QUOT_W-1:0] quot_o
);
  import wars_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [Q_W:0]      rem_q;
  logic [QUOT_W-1:0] sh_q;
  logic [QUOT_W-1:0] quot_q;
  logic [Q_W-1:0]    q_q;
  logic              ovf_q;
  logic [Q_W+1:0]    trial;
  logic [MAG_W-16:0] mag_hi;

  // The quotient is below 2^31 exactly when mag / 2^15 is below q, and then the
  // upper part of the dividend is already a valid partial remainder.
  assign mag_hi = mag_i[MAG_W-1:15];
  assign trial  = {rem_q, sh_q[QUOT_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(QUOT_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= q_i;
      ovf_q  <= (Q_W'(mag_hi) >= q_i);
      rem_q  <= (Q_W + 1)'(mag_hi);
      sh_q   <= {mag_i[14:0], 16'h0000};
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q <= {sh_q[QUOT_W-2:0], 1'b0};
      if (trial >= {2'b00, q_q}) begin
        rem_q  <= (Q_W + 1)'(trial - {2'b00, q_q});
        quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= trial[Q_W:0];
        quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? {QUOT_W{1'b1}} : quot_q;

endmodule

@@ rtl/core/wars_sqrt.sv @@
// Integer square root of a 64-bit value, one root bit a cycle.
`timescale 1ns / 1ps
module wars_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wars_pkg::SQ_W-1:0]   x_i,
  output logic                        done_o,
  output logic [wars_pkg::ROOT_W-1:0] root_o
);
  import wars_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [SQ_W-1:0]  x_q;
  logic [SQ_W-1:0]  r_q;
  logic [SQ_W-1:0]  bit_q;
  logic [SQ_W-1:0]  rb;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(ROOT_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (cnt_q != '0) begin
      bit_q <= bit_q >> 2;
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

@@ rtl/core/weighted_affine_residual_sum.sv @@
// Top level of the weighted affine residual sum block: point store, sequencer and datapath.
//
// Input channel s_axis: tuser carries the item kind, tlast marks the last weight of a row,
// tdata the payload. Output channel m_axis: tdata is the saturating Q32.32 row sum and
// tuser the row error flag; one transaction leaves for each weight item marked last.
// Items are taken one at a time. A load point item is written to the store as it is taken
// and the next item can follow at once. A begin row item runs two store reads, up to two
// halving steps, six products on the one shared multiplier and two divisions in the
// bit-serial divider, then four products for the offset; a row with an out-of-range index
// or equal anchor v values only sets the error flag. A weight item runs mostly in the
// bit-serial square root; a weight beyond the last column only sets the error flag. A last
// weight moves the sum into the output register, which lets the next item in while a result
// waits; only a second result stalls the sequencer until m_axis_tready takes the first.
// Reset clears slope, offset, sum, column count, error flag and the output valid; the
// point store is not cleared and holds nothing meaningful until loaded.
`timescale 1ns / 1ps
module weighted_affine_residual_sum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // point_index[9:0], v_re[41:10], v_im[73:42], fz_re[105:74], fz_im[137:106],
  // first_index[147:138], second_index[157:148], weight[189:158], zero fill above
  input  logic [wars_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]                       s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // row_sum[63:0]
  output logic [wars_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // error_flag[0]
  output logic                             m_axis_tuser_o
);
  import wars_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_HALVE,
    ST_SLOPE_MUL,
    ST_QUOT,
    ST_DRE_GO,
    ST_DRE,
    ST_DIM_GO,
    ST_DIM,
    ST_OFF_MUL,
    ST_OFF,
    ST_W_RD,
    ST_W_DATA,
    ST_W_MUL,
    ST_W_RES,
    ST_W_SQ,
    ST_W_ROOT_GO,
    ST_W_ROOT,
    ST_W_WMUL,
    ST_W_ACC,
    ST_EMIT
  } state_e;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [64:0] S64_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] S64_MIN = -65'sh0_8000_0000_0000_0000;
  localparam logic signed [32:0] LIM30   = 33'sd1073741824;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > S32_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (x < S32_MIN) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  // Halving that truncates toward zero.
  function automatic logic signed [32:0] halve(input logic signed [32:0] x);
    if (x[32]) begin
      return -((-x) >>> 1);
    end
    return x >>> 1;
  endfunction

  function automatic logic [MAG_W-1:0] abs64(input logic signed [63:0] x);
    logic signed [63:0] n;
    n = -x;
    return x[63] ? n[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  state_e state_q;
  logic [2:0] mstep_q;

  // Architectural row state.
  logic signed [31:0] slope_re_q, slope_im_q, offset_re_q, offset_im_q;
  logic signed [63:0] acc_q;
  logic [CW-1:0]      col_q;
  logic               err_q;

  logic               out_valid_q;
  logic [63:0]        out_data_q;
  logic               out_err_q;

  // Datapath registers.
  logic [IDX_W-1:0]   ia_q, ib_q;
  logic [AW-1:0]      j_q;
  logic signed [31:0] w_q;
  logic               last_q;
  point_t             pt_q;
  logic signed [32:0] nr_q, ni_q, dr_q, di_q;
  logic signed [63:0] p_q [6];
  logic signed [63:0] re_q, im_q;
  logic [Q_W-1:0]     q_q;
  logic signed [31:0] rr_q, ri_q;
  logic [ROOT_W-1:0]  mag_q;

  logic               accept;
  kind_e              in_kind;
  logic [IDX_W-1:0]   in_point_index, in_first, in_second;
  logic signed [31:0] in_weight;
  point_t             in_pt, rd_pt;
  logic [POINT_W-1:0] rd_data;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  logic               div_start, div_done;
  logic [MAG_W-1:0]   div_mag;
  logic [QUOT_W-1:0]  div_quot;
  logic               sqrt_start, sqrt_done;
  logic [SQ_W-1:0]    sqrt_x;
  logic [ROOT_W-1:0]  sqrt_root;

  logic signed [32:0] d_nr, d_ni, d_dr, d_di;
  logic signed [64:0] cv_re, cv_im;
  logic signed [64:0] acc_sum;
  logic signed [31:0] slope_div;
  logic               row_oob;

  assign in_kind        = kind_e'(s_axis_tuser_i);
  assign in_point_index = s_axis_tdata_i[9:0];
  assign in_pt.v_re     = s_axis_tdata_i[41:10];
  assign in_pt.v_im     = s_axis_tdata_i[73:42];
  assign in_pt.fz_re    = s_axis_tdata_i[105:74];
  assign in_pt.fz_im    = s_axis_tdata_i[137:106];
  assign in_first       = s_axis_tdata_i[147:138];
  assign in_second      = s_axis_tdata_i[157:148];
  assign in_weight      = s_axis_tdata_i[189:158];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign row_oob         = (32'(in_first) >= MAX_POINTS) || (32'(in_second) >= MAX_POINTS);

  assign ram_we = accept && (in_kind == KIND_LOAD) && (32'(in_point_index) < MAX_POINTS);

  always_comb begin
    case (state_q)
      ST_RD_A: ram_raddr = AW'(ia_q);
      ST_RD_B: ram_raddr = AW'(ib_q);
      default: ram_raddr = j_q;
    endcase
  end

  wars_ram #(
    .WIDTH(POINT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_point_index)),
    .wdata_i(in_pt),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign rd_pt = point_t'(rd_data);

  // Anchor differences; the second anchor arrives from the store in ST_DIFF.
  assign d_nr = 33'(pt_q.fz_re) - 33'(rd_pt.fz_re);
  assign d_ni = 33'(pt_q.fz_im) - 33'(rd_pt.fz_im);
  assign d_dr = 33'(rd_pt.v_re) - 33'(pt_q.v_re);
  assign d_di = 33'(rd_pt.v_im) - 33'(pt_q.v_im);

  // One shared multiplier, operands chosen by state and step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SLOPE_MUL: begin
        case (mstep_q)
          3'd0:    begin mul_a = 34'(nr_q); mul_b = 34'(dr_q); end
          3'd1:    begin mul_a = 34'(ni_q); mul_b = 34'(di_q); end
          3'd2:    begin mul_a = 34'(ni_q); mul_b = 34'(dr_q); end
          3'd3:    begin mul_a = 34'(nr_q); mul_b = 34'(di_q); end
          3'd4:    begin mul_a = 34'(dr_q); mul_b = 34'(dr_q); end
          default: begin mul_a = 34'(di_q); mul_b = 34'(di_q); end
        endcase
      end
      ST_OFF_MUL, ST_W_MUL: begin
        case (mstep_q)
          3'd0:    begin mul_a = 34'(slope_re_q); mul_b = 34'(pt_q.v_re); end
          3'd1:    begin mul_a = 34'(slope_im_q); mul_b = 34'(pt_q.v_im); end
          3'd2:    begin mul_a = 34'(slope_re_q); mul_b = 34'(pt_q.v_im); end
          default: begin mul_a = 34'(slope_im_q); mul_b = 34'(pt_q.v_re); end
        endcase
      end
      ST_W_SQ: begin
        if (mstep_q == 3'd0) begin
          mul_a = 34'(rr_q);
          mul_b = 34'(rr_q);
        end else begin
          mul_a = 34'(ri_q);
          mul_b = 34'(ri_q);
        end
      end
      ST_W_WMUL: begin
        mul_a = 34'(w_q);
        mul_b = $signed({2'b00, mag_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (state_q == ST_DRE_GO) || (state_q == ST_DIM_GO);
  assign div_mag   = (state_q == ST_DIM_GO) ? abs64(im_q) : abs64(re_q);

  wars_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (div_mag),
    .q_i    (q_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign sqrt_start = (state_q == ST_W_ROOT_GO);
  assign sqrt_x     = $unsigned(p_q[0]) + $unsigned(p_q[1]);

  wars_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .x_i    (sqrt_x),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  assign cv_re   = 65'(p_q[0]) - 65'(p_q[1]);
  assign cv_im   = 65'(p_q[2]) + 65'(p_q[3]);
  assign acc_sum = 65'(acc_q) + 65'(p_q[0]);

  always_comb begin
    logic signed [31:0] pos;
    pos = {1'b0, div_quot};
    if ((state_q == ST_DIM) ? im_q[63] : re_q[63]) begin
      slope_div = -pos;
    end else begin
      slope_div = pos;
    end
  end

  // Datapath registers, steered by the sequencer state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ia_q   <= in_first;
      ib_q   <= in_second;
      w_q    <= in_weight;
      last_q <= s_axis_tlast_i;
      j_q    <= col_q[AW-1:0];
    end
    case (state_q)
      ST_RD_B, ST_W_DATA: pt_q <= rd_pt;
      ST_DIFF: begin
        nr_q <= d_nr;
        ni_q <= d_ni;
        dr_q <= d_dr;
        di_q <= d_di;
      end
      ST_HALVE: begin
        if (dr_q >= LIM30 || dr_q <= -LIM30 || di_q >= LIM30 || di_q <= -LIM30) begin
          nr_q <= halve(nr_q);
          ni_q <= halve(ni_q);
          dr_q <= halve(dr_q);
          di_q <= halve(di_q);
        end
      end
      ST_SLOPE_MUL, ST_OFF_MUL, ST_W_MUL, ST_W_SQ, ST_W_WMUL: begin
        p_q[mstep_q] <= mul_p[63:0];
      end
      ST_QUOT: begin
        re_q <= p_q[0] + p_q[1];
        im_q <= p_q[2] - p_q[3];
        q_q  <= Q_W'($unsigned(p_q[4]) + $unsigned(p_q[5]));
      end
      ST_W_RES: begin
        rr_q <= sat32(66'(offset_re_q) + 66'(pt_q.fz_re) + 66'(cv_re >>> 16));
        ri_q <= sat32(66'(offset_im_q) + 66'(pt_q.fz_im) + 66'(cv_im >>> 16));
      end
      ST_W_ROOT: begin
        if (sqrt_done) begin
          mag_q <= sqrt_root;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer with the row state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mstep_q     <= '0;
      slope_re_q  <= '0;
      slope_im_q  <= '0;
      offset_re_q <= '0;
      offset_im_q <= '0;
      acc_q       <= '0;
      col_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_err_q   <= 1'b0;
    end else begin
      // In ST_EMIT the output valid is handled by the emit step alone.
      if (out_valid_q && m_axis_tready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_kind)
              KIND_ROW: begin
                acc_q       <= '0;
                col_q       <= '0;
                slope_re_q  <= '0;
                slope_im_q  <= '0;
                offset_re_q <= '0;
                offset_im_q <= '0;
                err_q       <= row_oob;
                if (!row_oob) begin
                  state_q <= ST_RD_A;
                end
              end
              KIND_WEIGHT: begin
                if (col_q >= CW'(MAX_POINTS)) begin
                  err_q <= 1'b1;
                  if (s_axis_tlast_i) begin
                    state_q <= ST_EMIT;
                  end
                end else begin
                  col_q   <= col_q + 1'b1;
                  state_q <= ST_W_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD_A: state_q <= ST_RD_B;
        ST_RD_B: state_q <= ST_DIFF;
        ST_DIFF: begin
          if (d_dr == '0 && d_di == '0) begin
            err_q   <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_HALVE;
          end
        end
        ST_HALVE: begin
          if (!(dr_q >= LIM30 || dr_q <= -LIM30 || di_q >= LIM30 || di_q <= -LIM30)) begin
            mstep_q <= '0;
            state_q <= ST_SLOPE_MUL;
          end
        end
        ST_SLOPE_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd5) begin
            state_q <= ST_QUOT;
          end
        end
        ST_QUOT:   state_q <= ST_DRE_GO;
        ST_DRE_GO: state_q <= ST_DRE;
        ST_DRE: begin
          if (div_done) begin
            slope_re_q <= slope_div;
            state_q    <= ST_DIM_GO;
          end
        end
        ST_DIM_GO: state_q <= ST_DIM;
        ST_DIM: begin
          if (div_done) begin
            slope_im_q <= slope_div;
            mstep_q    <= '0;
            state_q    <= ST_OFF_MUL;
          end
        end
        ST_OFF_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd3) begin
            state_q <= ST_OFF;
          end
        end
        ST_OFF: begin
          offset_re_q <= sat32(-66'(pt_q.fz_re) - 66'(cv_re >>> 16));
          offset_im_q <= sat32(-66'(pt_q.fz_im) - 66'(cv_im >>> 16));
          state_q     <= ST_IDLE;
        end
        ST_W_RD: state_q <= ST_W_DATA;
        ST_W_DATA: begin
          mstep_q <= '0;
          state_q <= ST_W_MUL;
        end
        ST_W_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd3) begin
            state_q <= ST_W_RES;
          end
        end
        ST_W_RES: begin
          mstep_q <= '0;
          state_q <= ST_W_SQ;
        end
        ST_W_SQ: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd1) begin
            state_q <= ST_W_ROOT_GO;
          end
        end
        ST_W_ROOT_GO: state_q <= ST_W_ROOT;
        ST_W_ROOT: begin
          if (sqrt_done) begin
            mstep_q <= '0;
            state_q <= ST_W_WMUL;
          end
        end
        ST_W_WMUL: state_q <= ST_W_ACC;
        ST_W_ACC: begin
          if (acc_sum > S64_MAX) begin
            acc_q <= S64_MAX[63:0];
          end else if (acc_sum < S64_MIN) begin
            acc_q <= S64_MIN[63:0];
          end else begin
            acc_q <= acc_sum[63:0];
          end
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q;
            out_err_q   <= err_q;
            acc_q       <= '0;
            col_q       <= '0;
            err_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule

@@ rtl/core/wars_checker.sv @@
// Port-level assertions for the weighted affine residual sum block, bound to its top level.
`timescale 1ns / 1ps
`include "weighted_affine_residual_sum_macros.svh"
module wars_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [wars_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [1:0]                       s_axis_tuser_i,
  input logic                             s_axis_tlast_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [wars_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import wars_pkg::*;

  logic in_acc;
  logic row_ok;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign row_ok = (32'(s_axis_tdata_i[147:138]) < MAX_POINTS)
               && (32'(s_axis_tdata_i[157:148]) < MAX_POINTS);

  // A waiting result keeps its value until it is taken.
  `WARS_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // A load is written as it is taken, so the next item is taken straight away.
  `WARS_ASSERT_NXT(a_load_ready, in_acc && (s_axis_tuser_i == KIND_LOAD), s_axis_tready_o)
  // A valid row begin starts the slope computation and holds the input off.
  `WARS_ASSERT_NXT(a_row_busy, in_acc && (s_axis_tuser_i == KIND_ROW) && row_ok,
    !s_axis_tready_o)
  // A new result is only loaded while the sequencer is away from idle.
  `WARS_ASSERT_IMP(a_emit_busy, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o))

endmodule

bind weighted_affine_residual_sum wars_checker u_wars_checker (.*);
